/* rtl/cfa_pkg.sv */
// Shared types and constants for the car-following acceleration block.
// Used by every module under rtl/ but cfa_checker; depends on nothing else.
`default_nettype none

package cfa_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROAD_ATTACHED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROAD_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_BIAS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_DIVISOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_LENGTH = 3'd5;

  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [15:0] GAP_DIVISOR_RST    = 16'd256;
  localparam logic [15:0] BRAKE_GAIN_RST     = 16'd256;
  localparam logic [15:0] NOMINAL_LENGTH_RST = 16'd1024;

  // Queue between front and back
  localparam int Q_DEPTH = 4;

  // Shared divider: 49-bit dividend (33 x 16 product), 32-bit divisor
  localparam int DIV_N_W = 49;
  localparam int DIV_D_W = 32;

  typedef struct packed {
    logic               road_attached;
    logic [14:0]        road_limit;
    logic signed [15:0] limit_bias;
    logic [15:0]        gap_divisor;
    logic [15:0]        brake_gain;
    logic [15:0]        nominal_length;
  } cfg_t;

  // What the back part has to do with an item
  typedef enum logic [1:0] {
    KIND_OWN,   // own-vehicle record, starts an evaluation
    KIND_SKIP,  // list entry that is the own vehicle
    KIND_CAND   // other vehicle, may become the leader
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] position;
    logic [14:0]        half_len;
    logic signed [15:0] speed;
    logic               last;
  } q_item_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/car_following_acceleration.sv */
// Top level of the car-following acceleration block: configuration registers,
// front stage, item queue, back part and shared divider. Depends on cfa_pkg.
//
//   channel  direction  handshake            payload
//   in_      in         in_valid / in_stall  command, position, body_length, speed,
//                                            is_own, last_item
//   out_     out        out_valid / out_stall acceleration, braking_for_leader
//   cfg_     in         cfg_valid / cfg_ready cfg_index (0..5), cfg_data
//
// Other-vehicle items go through the back part at one per cycle while it is not busy with an own item or a result.
// An own-vehicle item holds the back part while the preferred gap goes through the
// 49-step shared divider. A last item then passes an evaluation state to produce its
// result; braking for a leader may add a multiply and then the same divider.
// The 4-entry queue keeps the input taking items while the back part is busy;
// the output register frees the back part as soon as its result is taken.
// Reset is synchronous and active low; no clearing pass is needed.
`default_nettype none

module car_following_acceleration #(
  parameter int FRACTION_BITS = 8
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_command,
  input  wire  signed [23:0]                   in_position,
  input  wire         [15:0]                   in_body_length,
  input  wire  signed [15:0]                   in_speed,
  input  wire                                  in_is_own,
  input  wire                                  in_last_item,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [15:0]                   out_acceleration,
  output logic                                 out_braking_for_leader,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire         [cfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire         [cfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cfa_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      q_push, q_full, q_pop, q_empty;
  q_item_t   q_in_item, q_out_item;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ROAD_ATTACHED:  cfg_nxt.road_attached  = cfg_data[0];
        CFG_ROAD_LIMIT:     cfg_nxt.road_limit     = cfg_data[14:0];
        CFG_LIMIT_BIAS:     cfg_nxt.limit_bias     = cfg_data;
        CFG_GAP_DIVISOR:    cfg_nxt.gap_divisor    = cfg_data;
        CFG_BRAKE_GAIN:     cfg_nxt.brake_gain     = cfg_data;
        CFG_NOMINAL_LENGTH: cfg_nxt.nominal_length = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.road_attached  <= 1'b0;
      cfg_r.road_limit     <= '0;
      cfg_r.limit_bias     <= '0;
      cfg_r.gap_divisor    <= GAP_DIVISOR_RST;
      cfg_r.brake_gain     <= BRAKE_GAIN_RST;
      cfg_r.nominal_length <= NOMINAL_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cfa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_position    (in_position),
    .in_body_length (in_body_length),
    .in_speed       (in_speed),
    .in_is_own      (in_is_own),
    .in_last_item   (in_last_item),
    .q_push         (q_push),
    .q_item         (q_in_item),
    .q_full         (q_full)
  );

  cfa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .empty     (q_empty)
  );

  cfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  cfa_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .q_item                 (q_out_item),
    .q_empty                (q_empty),
    .q_pop                  (q_pop),
    .div_req                (div_req),
    .div_rsp                (div_rsp),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_acceleration       (out_acceleration),
    .out_braking_for_leader (out_braking_for_leader)
  );

endmodule

`default_nettype wire

/* rtl/cfa_front.sv */
// Front part: input register stage that classifies each item for the back part.
// Depends on cfa_pkg.
`default_nettype none

module cfa_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_command,
  input  wire  signed [23:0]   in_position,
  input  wire         [15:0]   in_body_length,
  input  wire  signed [15:0]   in_speed,
  input  wire                  in_is_own,
  input  wire                  in_last_item,
  output logic                 q_push,
  output cfa_pkg::q_item_t     q_item,
  input  wire                  q_full
);
  import cfa_pkg::*;

  logic     fr_valid_r, fr_valid_nxt;
  q_item_t  fr_item_r, fr_item_nxt;
  logic     take;

  assign in_stall = fr_valid_r && q_full;
  assign take     = in_valid && !in_stall;
  assign q_push   = fr_valid_r && !q_full;
  assign q_item   = fr_item_r;

  always_comb begin
    fr_item_nxt = fr_item_r;
    if (take) begin
      if (!in_command) begin
        fr_item_nxt.kind = KIND_OWN;
      end else if (in_is_own) begin
        fr_item_nxt.kind = KIND_SKIP;
      end else begin
        fr_item_nxt.kind = KIND_CAND;
      end
      fr_item_nxt.position = in_position;
      fr_item_nxt.half_len = in_body_length[15:1];
      fr_item_nxt.speed    = in_speed;
      fr_item_nxt.last     = in_last_item;
    end
    if (take) begin
      fr_valid_nxt = 1'b1;
    end else if (q_push) begin
      fr_valid_nxt = 1'b0;
    end else begin
      fr_valid_nxt = fr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    fr_item_r <= fr_item_nxt;
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/cfa_fifo.sv */
// Short item queue between the front and back parts.
// Depends on cfa_pkg.
`default_nettype none

module cfa_fifo (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  cfa_pkg::q_item_t  push_item,
  output logic              full,
  input  wire               pop,
  output cfa_pkg::q_item_t  pop_item,
  output logic              empty
);
  import cfa_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  q_item_t            slot_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == CNT_W'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/cfa_div.sv */
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on cfa_pkg.
`default_nettype none

module cfa_div (
  input  wire                clk,
  input  wire                rst_n,
  input  cfa_pkg::div_req_t  req,
  output cfa_pkg::div_rsp_t  rsp
);
  import cfa_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] quo_r, quo_nxt;
  logic [DIV_D_W-1:0] rem_r, rem_nxt;
  logic [DIV_D_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DIV_D_W:0]   rem_sh;
  logic               ge;

  assign rem_sh = {rem_r, quo_r[DIV_N_W-1]};
  assign ge     = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = CNT_W'(DIV_N_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_N_W-2:0], ge};
      rem_nxt = ge ? DIV_D_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DIV_D_W-1:0];
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

/* rtl/cfa_back.sv */
// Back part: vehicle state, leader search, evaluation and result register.
// Depends on cfa_pkg; drives the shared divider cfa_div.
`default_nettype none

module cfa_back #(
  parameter int FRACTION_BITS = 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  cfa_pkg::cfg_t       cfg,
  input  cfa_pkg::q_item_t    q_item,
  input  wire                 q_empty,
  output logic                q_pop,
  output cfa_pkg::div_req_t   div_req,
  input  cfa_pkg::div_rsp_t   div_rsp,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic signed [15:0]  out_acceleration,
  output logic                out_braking_for_leader
);
  import cfa_pkg::*;

  // Plus and minus one in Q.F, saturated to 16 bits
  localparam int OneInt = 1 << FRACTION_BITS;
  localparam logic signed [15:0] AccUp   = (OneInt > 32767) ? 16'sh7FFF : 16'(OneInt);
  localparam logic signed [15:0] AccDown = (OneInt > 32768) ? 16'sh8000 : 16'(-OneInt);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_PREF,
    S_EVAL,
    S_MUL,
    S_DIV_BRK,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic signed [23:0] own_centre_r, own_centre_nxt;
  logic signed [24:0] own_head_r, own_head_nxt;
  logic signed [15:0] own_vel_r, own_vel_nxt;
  logic signed [31:0] pref_r, pref_nxt;
  logic               leader_r, leader_nxt;
  logic signed [25:0] gap_r, gap_nxt;
  logic signed [15:0] last_acc_r, last_acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  // payload, no reset
  logic               last_pend_r, last_pend_nxt;
  logic               neg_r, neg_nxt;
  logic [32:0]        num_r, num_nxt;
  logic signed [15:0] res_acc_r, res_acc_nxt;
  logic               res_brk_r, res_brk_nxt;
  logic signed [15:0] out_acc_r, out_acc_nxt;
  logic               out_brk_r, out_brk_nxt;

  logic               out_free;
  logic [15:0]        spd_mag;
  logic [32:0]        mul_a;
  logic [15:0]        mul_b;
  logic [DIV_N_W-1:0] product;
  logic signed [25:0] cand_gap;
  logic               cand_hit;
  logic signed [16:0] target;
  logic signed [16:0] vel_ext;
  logic               vel_pos;
  logic               pref_pos;
  logic               needs_div;
  logic signed [15:0] eval_acc;
  logic               eval_brk;
  logic [15:0]        q_neg;

  assign out_free = !out_valid_r || !out_stall;

  // Magnitude of the own speed; -32768 maps to 32768 unsigned
  assign spd_mag = q_item.speed[15] ? 16'(-q_item.speed) : q_item.speed;

  // One multiplier, shared by the preferred gap and the braking numerator
  assign mul_a   = (state_r == S_MUL) ? num_r : {17'b0, spd_mag};
  assign mul_b   = (state_r == S_MUL) ? cfg.brake_gain : cfg.nominal_length;
  assign product = DIV_N_W'(mul_a) * DIV_N_W'(mul_b);

  // Gap from own head to the tail of a candidate
  assign cand_gap = {{2{q_item.position[23]}}, q_item.position}
                  - {11'b0, q_item.half_len}
                  - {own_head_r[24], own_head_r};
  assign cand_hit = !leader_r && (q_item.position >= own_centre_r)
                  && ($signed({{6{cand_gap[25]}}, cand_gap}) < pref_r);

  assign target   = $signed({2'b00, cfg.road_limit})
                  + $signed({cfg.limit_bias[15], cfg.limit_bias});
  assign vel_ext  = {own_vel_r[15], own_vel_r};
  assign vel_pos  = (own_vel_r > 16'sd0);
  assign pref_pos = (pref_r > 32'sd0);
  assign needs_div = cfg.road_attached && leader_r && vel_pos && pref_pos;
  // quotient is at most 32768 here, so 16 bits carry its negation
  assign q_neg    = 16'(16'd0 - div_rsp.quotient[15:0]);

  always_comb begin
    eval_brk = cfg.road_attached && leader_r;
    eval_acc = '0;
    if (!cfg.road_attached) begin
      eval_acc = '0;
    end else if (leader_r) begin
      if (!vel_pos) begin
        eval_acc = '0;
      end else if (!pref_pos) begin
        // no room at all: hardest braking unless the gain is zero
        eval_acc = (cfg.brake_gain != '0) ? 16'sh8000 : 16'sh0000;
      end else begin
        eval_acc = '0;
      end
    end else if (vel_ext < target) begin
      eval_acc = AccUp;
    end else if (vel_ext > target) begin
      eval_acc = vel_pos ? AccDown : 16'sh0000;
    end else begin
      eval_acc = last_acc_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    own_centre_nxt = own_centre_r;
    own_head_nxt   = own_head_r;
    own_vel_nxt    = own_vel_r;
    pref_nxt       = pref_r;
    leader_nxt     = leader_r;
    gap_nxt        = gap_r;
    last_acc_nxt   = last_acc_r;
    last_pend_nxt  = last_pend_r;
    neg_nxt        = neg_r;
    num_nxt        = num_r;
    res_acc_nxt    = res_acc_r;
    res_brk_nxt    = res_brk_r;
    out_acc_nxt    = out_acc_r;
    out_brk_nxt    = out_brk_r;
    out_valid_nxt  = out_valid_r && out_stall;
    q_pop          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = product;
    div_req.divisor  = (state_r == S_MUL) ? DIV_D_W'(pref_r)
                     : (cfg.gap_divisor == '0) ? DIV_D_W'(1)
                     : DIV_D_W'(cfg.gap_divisor);

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          last_pend_nxt = q_item.last;
          case (q_item.kind)
            KIND_OWN: begin
              own_centre_nxt = q_item.position;
              own_head_nxt   = {q_item.position[23], q_item.position}
                             + {10'b0, q_item.half_len};
              own_vel_nxt    = q_item.speed;
              leader_nxt     = 1'b0;
              gap_nxt        = '0;
              neg_nxt        = q_item.speed[15];
              div_req.start  = 1'b1;
              state_nxt      = S_DIV_PREF;
            end
            KIND_CAND: begin
              if (cand_hit) begin
                leader_nxt = 1'b1;
                gap_nxt    = cand_gap;
              end
              state_nxt = q_item.last ? S_EVAL : S_IDLE;
            end
            default: begin
              state_nxt = q_item.last ? S_EVAL : S_IDLE;
            end
          endcase
        end
      end
      S_DIV_PREF: begin
        if (div_rsp.done) begin
          // quotient truncated toward zero, sign restored afterwards
          pref_nxt  = neg_r ? 32'(-div_rsp.quotient[31:0]) : div_rsp.quotient[31:0];
          state_nxt = last_pend_r ? S_EVAL : S_IDLE;
        end
      end
      S_EVAL: begin
        res_acc_nxt = eval_acc;
        res_brk_nxt = eval_brk;
        num_nxt     = 33'({pref_r[31], pref_r} - {{7{gap_r[25]}}, gap_r});
        state_nxt   = needs_div ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIV_BRK;
      end
      S_DIV_BRK: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient > DIV_N_W'(32768)) begin
            res_acc_nxt = 16'sh8000;
          end else begin
            res_acc_nxt = q_neg;
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = res_acc_r;
          out_brk_nxt   = res_brk_r;
          last_acc_nxt  = res_acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    last_pend_r <= last_pend_nxt;
    neg_r       <= neg_nxt;
    num_r       <= num_nxt;
    res_acc_r   <= res_acc_nxt;
    res_brk_r   <= res_brk_nxt;
    out_acc_r   <= out_acc_nxt;
    out_brk_r   <= out_brk_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      own_centre_r <= '0;
      own_head_r   <= '0;
      own_vel_r    <= '0;
      pref_r       <= '0;
      leader_r     <= 1'b0;
      gap_r        <= '0;
      last_acc_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      own_centre_r <= own_centre_nxt;
      own_head_r   <= own_head_nxt;
      own_vel_r    <= own_vel_nxt;
      pref_r       <= pref_nxt;
      leader_r     <= leader_nxt;
      gap_r        <= gap_nxt;
      last_acc_r   <= last_acc_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_acceleration       = out_acc_r;
  assign out_braking_for_leader = out_brk_r;

endmodule

`default_nettype wire

/* rtl/cfa_checker.sv */
// Port-level checks for car_following_acceleration, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module cfa_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input wire signed [15:0] out_acceleration,
  input wire               out_braking_for_leader
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_acceleration)
                               && $stable(out_braking_for_leader))
    else $error("result changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled straight after reset");

  // braking for a leader never asks for positive acceleration
  a_brake_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_braking_for_leader |->
      out_acceleration[15] || (out_acceleration == 16'sd0))
    else $error("positive acceleration while braking for leader");

endmodule

bind car_following_acceleration cfa_checker u_cfa_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_acceleration       (out_acceleration),
  .out_braking_for_leader (out_braking_for_leader)
);

`default_nettype wire
